/* hw/rtl/rtcbl_pkg.sv */
// Shared types, constants and helper functions of the RTC BCD to local date/time unit.
`default_nettype none

package rtcbl_pkg;

    // Offset register: quarter hours biased so that the reset value means UTC+0
    localparam int OFFSET_RESET = 48;
    localparam int OFFSET_BIAS  = 48;
    localparam int OFFSET_MAX   = 104;
    localparam int QUARTER_MIN  = 15;

    localparam int MIN_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int NOON_HOUR     = 12;

    localparam int MONTH_JAN = 1;
    localparam int MONTH_FEB = 2;
    localparam int MONTH_DEC = 12;

    localparam int YEAR_BASE = 2000;
    // Only century year within reach of the two-digit year (plus or minus a day) that is not leap
    localparam int YEAR_CENTURY_COMMON = 2100;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_UTC_OFFSET = 1'b0;

    typedef struct packed {
        logic [7:0] raw_minutes;
        logic [7:0] raw_hours;
        logic [7:0] raw_weekday;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [2:0]  local_weekday;
        logic [5:0]  local_day;
        logic [3:0]  local_month;
        logic [11:0] local_year;
        logic [5:0]  local_hour;
        logic [5:0]  local_minute;
    } t_out;

    // Decoded register snapshot, handed from the decoder to the rollover logic
    typedef struct packed {
        logic [6:0] minute;
        logic [5:0] hour;
        logic [2:0] weekday;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
    } t_dec;

    // Two BCD digits taken at face value: tens * 10 + ones
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'b0000, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'b0000, b[3:0]};
    endfunction

    // Days in month mo (1..12) of full year yr (1999..2166)
    function automatic logic [4:0] month_days(input logic [3:0] mo, input logic [11:0] yr);
        logic       leap;
        logic [4:0] len;
        leap = (yr[1:0] == 2'b00) && (yr != 12'(YEAR_CENTURY_COMMON));
        case (mo)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rtcbl_decode.sv */
// BCD decode of the raw clock register bytes, with 12h to 24h conversion.
`default_nettype none

module rtcbl_decode
    import rtcbl_pkg::*;
(
    input  t_in  i_raw,
    output t_dec o_dec
);

    logic [7:0] min_full;
    logic [7:0] h12_full;
    logic [7:0] h12;
    logic [7:0] h24_full;
    logic [7:0] hour_full;
    logic [7:0] day_full;
    logic [7:0] month_full;

    assign min_full   = bcd_val({1'b0, i_raw.raw_minutes[6:0]});
    assign h12_full   = bcd_val({3'b000, i_raw.raw_hours[4:0]});
    assign h24_full   = bcd_val({2'b00, i_raw.raw_hours[5:0]});
    assign day_full   = bcd_val({2'b00, i_raw.raw_day[5:0]});
    assign month_full = bcd_val({3'b000, i_raw.raw_month[4:0]});

    // Twelve o'clock counts as hour zero before PM is applied
    assign h12 = (h12_full == 8'(NOON_HOUR)) ? 8'd0 : h12_full;

    always_comb begin
        if (i_raw.raw_hours[6]) begin
            hour_full = i_raw.raw_hours[5] ? h12 + 8'(NOON_HOUR) : h12;
        end else begin
            hour_full = h24_full;
        end
    end

    assign o_dec.minute  = min_full[6:0];
    assign o_dec.hour    = hour_full[5:0];
    assign o_dec.weekday = i_raw.raw_weekday[2:0];
    assign o_dec.day     = day_full[5:0];
    assign o_dec.month   = month_full[4:0];
    assign o_dec.year    = bcd_val(i_raw.raw_year);

endmodule

`default_nettype wire

/* hw/rtl/rtcbl_roll.sv */
// UTC offset addition and one-day calendar rollover on decoded clock fields.
`default_nettype none

module rtcbl_roll
    import rtcbl_pkg::*;
(
    input  t_dec       i_dec,
    input  logic [7:0] i_offset,
    output t_out       o_res
);

    logic               ok;
    logic [6:0]         off_c;
    logic signed [7:0]  dq;
    logic signed [7:0]  dh;
    logic [5:0]         dm;
    logic [7:0]         msum;
    logic [7:0]         mloc;
    logic [1:0]         carry;
    logic signed [7:0]  hsum;
    logic signed [7:0]  hloc;
    logic               back;
    logic               fwd;
    logic [3:0]         mo;
    logic [11:0]        yr;
    logic [3:0]         prev_mo;
    logic [11:0]        prev_yr;
    logic [3:0]         next_mo;
    logic [11:0]        next_yr;
    logic [4:0]         prev_len;
    logic [4:0]         cur_len;
    logic [5:0]         day_inc;
    logic [5:0]         day_loc;
    logic [3:0]         mo_loc;
    logic [11:0]        yr_loc;
    logic [2:0]         wd_loc;

    always_comb begin
        ok = (i_dec.month >= 5'(MONTH_JAN)) && (i_dec.month <= 5'(MONTH_DEC));

        // Split the offset into whole hours (floor) and the leftover quarters
        off_c = (i_offset > 8'(OFFSET_MAX)) ? 7'(OFFSET_MAX) : i_offset[6:0];
        dq    = $signed({1'b0, off_c}) - $signed(8'(OFFSET_BIAS));
        dh    = dq >>> 2;
        dm    = 6'(dq[1:0]) * 6'(QUARTER_MIN);

        // Normalise minutes, carrying at most two hours
        msum = {1'b0, i_dec.minute} + {2'b00, dm};
        if (msum >= 8'(2 * MIN_PER_HOUR)) begin
            mloc  = msum - 8'(2 * MIN_PER_HOUR);
            carry = 2'd2;
        end else if (msum >= 8'(MIN_PER_HOUR)) begin
            mloc  = msum - 8'(MIN_PER_HOUR);
            carry = 2'd1;
        end else begin
            mloc  = msum;
            carry = 2'd0;
        end

        hsum = $signed({2'b00, i_dec.hour}) + dh + $signed({6'b000000, carry});
        back = hsum[7];
        fwd  = !back && (hsum >= $signed(8'(HOURS_PER_DAY)));
        if (back) begin
            hloc = hsum + $signed(8'(HOURS_PER_DAY));
        end else if (fwd) begin
            hloc = hsum - $signed(8'(HOURS_PER_DAY));
        end else begin
            hloc = hsum;
        end

        // Neighbouring months with year wrap
        mo = i_dec.month[3:0];
        yr = 12'(YEAR_BASE) + {4'b0000, i_dec.year};
        if (mo == 4'(MONTH_JAN)) begin
            prev_mo = 4'(MONTH_DEC);
            prev_yr = yr - 12'd1;
        end else begin
            prev_mo = mo - 4'd1;
            prev_yr = yr;
        end
        if (mo == 4'(MONTH_DEC)) begin
            next_mo = 4'(MONTH_JAN);
            next_yr = yr + 12'd1;
        end else begin
            next_mo = mo + 4'd1;
            next_yr = yr;
        end
        prev_len = month_days(prev_mo, prev_yr);
        cur_len  = month_days(mo, yr);
        day_inc  = i_dec.day + 6'd1;

        day_loc = i_dec.day;
        mo_loc  = mo;
        yr_loc  = yr;
        wd_loc  = i_dec.weekday;
        if (back) begin
            // Day zero or one drops to the last day of the previous month
            if (i_dec.day <= 6'd1) begin
                day_loc = {1'b0, prev_len};
                mo_loc  = prev_mo;
                yr_loc  = prev_yr;
            end else begin
                day_loc = i_dec.day - 6'd1;
            end
            wd_loc = (i_dec.weekday <= 3'd1) ? i_dec.weekday + 3'd6 : i_dec.weekday - 3'd1;
        end else if (fwd) begin
            if (day_inc > {1'b0, cur_len}) begin
                day_loc = 6'd1;
                mo_loc  = next_mo;
                yr_loc  = next_yr;
            end else begin
                day_loc = day_inc;
            end
            wd_loc = (i_dec.weekday == 3'd7) ? 3'd1 : i_dec.weekday + 3'd1;
        end

        if (ok) begin
            o_res.ok            = 1'b1;
            o_res.local_weekday = wd_loc;
            o_res.local_day     = day_loc;
            o_res.local_month   = mo_loc;
            o_res.local_year    = yr_loc;
            o_res.local_hour    = hloc[5:0];
            o_res.local_minute  = mloc[5:0];
        end else begin
            o_res = '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rtc_bcd_to_local_date_time_unit.sv */
// Top level: input register, decode and rollover logic, result register and offset register.
// Throughput: one item per cycle; the whole conversion is a single pass of logic between the two
// registers, so a new transfer is taken every cycle while the result side keeps up.
// Reset: synchronous, active low; clears both valid flags and sets the UTC offset register to 48
// (UTC+0). Payload registers are not reset.
`default_nettype none

module rtc_bcd_to_local_date_time_unit
    import rtcbl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,

    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,

    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Pipeline registers
    logic       r_in_vld;
    t_in        r_in;
    logic       r_out_vld;
    t_out       r_out;
    logic [7:0] r_offset;

    logic       adv_out;
    logic       adv_in;
    logic       cfg_wr;
    t_dec       dec;
    t_out       n_out;

    // The result register may load when empty or when its transfer completes this cycle;
    // the input register may load when empty or when it hands on to the result register.
    assign adv_out    = !r_out_vld || !i_out_stall;
    assign adv_in     = !r_in_vld || adv_out;
    assign o_in_stall = !adv_in;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Decode the held snapshot, then apply the offset and roll the date
    rtcbl_decode u_decode (
        .i_raw (r_in),
        .o_dec (dec)
    );

    rtcbl_roll u_roll (
        .i_dec    (dec),
        .i_offset (r_offset),
        .o_res    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_vld <= i_in_valid;
            end
            if (adv_out) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && adv_in) begin
            r_in <= i_in_data;
        end
        if (r_in_vld && adv_out) begin
            r_out <= n_out;
        end
    end

    // Configuration: a single byte-wide register at word 0; writes elsewhere are dropped
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UTC_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 8'(OFFSET_RESET);
        end else if (cfg_wr) begin
            r_offset <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_UTC_OFFSET) ? {{(APB_DATA_W-8){1'b0}}, r_offset} : '0;

endmodule

`default_nettype wire
